// ===== src/rode_pkg.sv =====
// Shared types, constants and the step microcode of the Riccati ODE stepper.
package rode_pkg;

  localparam int unsigned FracBitsDef = 40;
  localparam int unsigned DataW       = 64;
  localparam int unsigned StepW       = 41;
  localparam int unsigned IhsW        = 63;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 63;

  localparam logic [CfgIdxW-1:0] RegMethod = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStep   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIhs    = 2'd2;

  localparam logic [1:0]       MethodRst = 2'd0;
  localparam logic [StepW-1:0] StepRst   = 41'd10995116;
  localparam logic [IhsW-1:0]  IhsRst    = 63'd54975581388800000;

  localparam logic [1:0] MethExplicit = 2'd0;
  localparam logic [1:0] MethImplicit = 2'd1;
  localparam logic [1:0] MethMidpoint = 2'd2;

  localparam logic [1:0] StatOk  = 2'd0;
  localparam logic [1:0] StatOvf = 2'd1;
  localparam logic [1:0] StatNeg = 2'd2;

  localparam logic [DataW-1:0] SMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_SQRT
  } op_e;

  typedef enum logic [3:0] {
    SRC_R0,
    SRC_R1,
    SRC_R2,
    SRC_R3,
    SRC_Y,
    SRC_H,
    SRC_C,
    SRC_IHS,
    SRC_XP,
    SRC_XN,
    SRC_ONE
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    src_e dst;
    logic last;
  } uop_t;

  typedef struct packed {
    logic load;
    logic zero_y;
    logic start;
    uop_t uop;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic neg;
  } dp_stat_t;

  function automatic uop_t mk(op_e op, src_e a, src_e b, src_e dst, logic last);
    uop_t u;
    u.op   = op;
    u.a    = a;
    u.b    = b;
    u.dst  = dst;
    u.last = last;
    return u;
  endfunction

  function automatic uop_t ucode(logic [1:0] method, logic [3:0] pc);
    uop_t u;
    u = mk(OP_ADD, SRC_Y, SRC_R0, SRC_Y, 1'b1);
    case (method)
      MethImplicit: begin
        case (pc)
          4'd0:  u = mk(OP_MUL,  SRC_H,   SRC_Y,   SRC_R0, 1'b0);
          4'd1:  u = mk(OP_ADD,  SRC_R0,  SRC_R0,  SRC_R0, 1'b0);
          4'd2:  u = mk(OP_ADD,  SRC_R0,  SRC_R0,  SRC_R0, 1'b0);
          4'd3:  u = mk(OP_MUL,  SRC_H,   SRC_XN,  SRC_R1, 1'b0);
          4'd4:  u = mk(OP_MUL,  SRC_R1,  SRC_R1,  SRC_R1, 1'b0);
          4'd5:  u = mk(OP_ADD,  SRC_R1,  SRC_R1,  SRC_R1, 1'b0);
          4'd6:  u = mk(OP_ADD,  SRC_R1,  SRC_R1,  SRC_R1, 1'b0);
          4'd7:  u = mk(OP_SUB,  SRC_ONE, SRC_R0,  SRC_R2, 1'b0);
          4'd8:  u = mk(OP_SUB,  SRC_R2,  SRC_R1,  SRC_R2, 1'b0);
          4'd9:  u = mk(OP_SQRT, SRC_R2,  SRC_R2,  SRC_R3, 1'b0);
          4'd10: u = mk(OP_SUB,  SRC_ONE, SRC_R3,  SRC_R3, 1'b0);
          default: u = mk(OP_MUL, SRC_R3, SRC_IHS, SRC_Y,  1'b1);
        endcase
      end
      MethMidpoint: begin
        case (pc)
          4'd0:  u = mk(OP_MUL, SRC_XP, SRC_XP, SRC_R0, 1'b0);
          4'd1:  u = mk(OP_MUL, SRC_Y,  SRC_Y,  SRC_R1, 1'b0);
          4'd2:  u = mk(OP_ADD, SRC_R0, SRC_R1, SRC_R0, 1'b0);
          4'd3:  u = mk(OP_ADD, SRC_XP, SRC_C,  SRC_R2, 1'b0);
          4'd4:  u = mk(OP_MUL, SRC_C,  SRC_R0, SRC_R0, 1'b0);
          4'd5:  u = mk(OP_ADD, SRC_Y,  SRC_R0, SRC_R3, 1'b0);
          4'd6:  u = mk(OP_MUL, SRC_R2, SRC_R2, SRC_R0, 1'b0);
          4'd7:  u = mk(OP_MUL, SRC_R3, SRC_R3, SRC_R1, 1'b0);
          4'd8:  u = mk(OP_ADD, SRC_R0, SRC_R1, SRC_R0, 1'b0);
          4'd9:  u = mk(OP_MUL, SRC_H,  SRC_R0, SRC_R0, 1'b0);
          default: u = mk(OP_ADD, SRC_Y, SRC_R0, SRC_Y,  1'b1);
        endcase
      end
      default: begin
        case (pc)
          4'd0:  u = mk(OP_MUL, SRC_XP, SRC_XP, SRC_R0, 1'b0);
          4'd1:  u = mk(OP_MUL, SRC_Y,  SRC_Y,  SRC_R1, 1'b0);
          4'd2:  u = mk(OP_ADD, SRC_R0, SRC_R1, SRC_R0, 1'b0);
          4'd3:  u = mk(OP_MUL, SRC_H,  SRC_R0, SRC_R0, 1'b0);
          default: u = mk(OP_ADD, SRC_Y, SRC_R0, SRC_Y,  1'b1);
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

// ===== src/rode_ctrl.sv =====
// Sequencer that walks the step microcode and drives the output handshake.
module rode_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          method_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rode_pkg::cmd_t      cmd_o,
  input  rode_pkg::dp_stat_t  stat_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StWait  = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [3:0]     pc_q, pc_d;
  logic           out_valid_q, out_valid_d;
  rode_pkg::uop_t uop;

  assign uop         = rode_pkg::ucode(method_i, pc_q);
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    cmd_o        = '0;
    cmd_o.uop    = uop;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pc_d       = 4'd0;
          if (restart_i) begin
            cmd_o.zero_y = 1'b1;
            state_d      = StFin;
          end else begin
            state_d = StIssue;
          end
        end
      end
      StIssue: begin
        cmd_o.start = 1'b1;
        state_d     = StWait;
      end
      StWait: begin
        if (stat_i.done) begin
          if (stat_i.neg || uop.last) begin
            state_d = StFin;
          end else begin
            pc_d    = pc_q + 4'd1;
            state_d = StIssue;
          end
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pc_q        <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/rode_dp.sv =====
// Datapath: working registers, multi-cycle multiplier and bit-serial square root.
module rode_dp #(
  parameter int unsigned FRAC_BITS = rode_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rode_pkg::cmd_t              cmd_i,
  output rode_pkg::dp_stat_t          stat_o,
  input  logic [rode_pkg::StepW-1:0]  step_i,
  input  logic [rode_pkg::IhsW-1:0]   ihs_i,
  input  logic [63:0]                 x_prev_i,
  input  logic [63:0]                 x_next_i,
  output logic [63:0]                 y_value_o,
  output logic [1:0]                  status_o
);

  localparam logic [63:0]  One = 64'd1 << FRAC_BITS;
  localparam logic [127:0] Rnd = 128'd1 << (FRAC_BITS - 1);

  logic [63:0]     r0_q, r1_q, r2_q, r3_q, y_q, xp_q, xn_q;
  logic [63:0]     opa_q, opb_q, ma_q, mb_q, root_q;
  logic [127:0]    acc_q;
  logic [65:0]     rem_q;
  logic            mneg_q, busy_q, done_q, ovf_q, neg_q;
  rode_pkg::op_e   op_q;
  rode_pkg::src_e  dst_q;
  logic [6:0]      cnt_q;
  logic [63:0]     yout_q;
  logic [1:0]      stout_q;

  logic [63:0]  src_a, src_b, h_ext, c_ext;
  logic [63:0]  add_s, sub_s, wr_val, mul_m;
  logic         add_o, sub_o, wr_en, ovf_set, neg_set;
  logic [127:0] p_r, pp_sh;
  logic [1:0]   pp_sel;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [65:0]  rem_n, trial, rem_d;
  logic [63:0]  root_d;
  logic         ge;

  assign h_ext = {{(64-rode_pkg::StepW){1'b0}}, step_i};
  assign c_ext = {{(65-rode_pkg::StepW){1'b0}}, step_i[rode_pkg::StepW-1:1]};

  function automatic logic [63:0] pick(rode_pkg::src_e s, logic [63:0] r0, logic [63:0] r1,
                                       logic [63:0] r2, logic [63:0] r3, logic [63:0] y,
                                       logic [63:0] h, logic [63:0] c, logic [63:0] ihs,
                                       logic [63:0] xp, logic [63:0] xn);
    logic [63:0] v;
    case (s)
      rode_pkg::SRC_R0:  v = r0;
      rode_pkg::SRC_R1:  v = r1;
      rode_pkg::SRC_R2:  v = r2;
      rode_pkg::SRC_R3:  v = r3;
      rode_pkg::SRC_Y:   v = y;
      rode_pkg::SRC_H:   v = h;
      rode_pkg::SRC_C:   v = c;
      rode_pkg::SRC_IHS: v = ihs;
      rode_pkg::SRC_XP:  v = xp;
      rode_pkg::SRC_XN:  v = xn;
      rode_pkg::SRC_ONE: v = One;
      default:           v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    src_a = pick(cmd_i.uop.a, r0_q, r1_q, r2_q, r3_q, y_q, h_ext, c_ext,
                 {1'b0, ihs_i}, xp_q, xn_q);
    src_b = pick(cmd_i.uop.b, r0_q, r1_q, r2_q, r3_q, y_q, h_ext, c_ext,
                 {1'b0, ihs_i}, xp_q, xn_q);
  end

  // saturating add / sub
  assign add_s = opa_q + opb_q;
  assign sub_s = opa_q - opb_q;
  assign add_o = (opa_q[63] == opb_q[63]) && (add_s[63] != opa_q[63]);
  assign sub_o = (opa_q[63] != opb_q[63]) && (sub_s[63] != opa_q[63]);

  // one 32x32 partial product per cycle
  assign pp_sel = 2'(cnt_q - 7'd1);
  assign a_half = pp_sel[0] ? ma_q[63:32] : ma_q[31:0];
  assign b_half = pp_sel[1] ? mb_q[63:32] : mb_q[31:0];
  assign pp     = 64'(a_half) * 64'(b_half);
  always_comb begin
    case (pp_sel)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign p_r   = acc_q + Rnd;
  assign mul_m = p_r[63+FRAC_BITS:FRAC_BITS];

  // one root bit per cycle
  assign rem_n  = {rem_q[63:0], acc_q[127:126]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_n >= trial);
  assign rem_d  = ge ? (rem_n - trial) : rem_n;
  assign root_d = {root_q[62:0], ge};

  always_comb begin
    wr_en   = 1'b0;
    wr_val  = '0;
    ovf_set = 1'b0;
    neg_set = 1'b0;
    if (busy_q) begin
      case (op_q)
        rode_pkg::OP_ADD: begin
          wr_en   = 1'b1;
          ovf_set = add_o;
          wr_val  = add_o ? (opa_q[63] ? rode_pkg::SMin : rode_pkg::SMax) : add_s;
        end
        rode_pkg::OP_SUB: begin
          wr_en   = 1'b1;
          ovf_set = sub_o;
          wr_val  = sub_o ? (opa_q[63] ? rode_pkg::SMin : rode_pkg::SMax) : sub_s;
        end
        rode_pkg::OP_MUL: begin
          if (cnt_q == 7'd5) begin
            wr_en = 1'b1;
            if (|p_r[127:64+FRAC_BITS]) begin
              ovf_set = 1'b1;
              wr_val  = mneg_q ? rode_pkg::SMin : rode_pkg::SMax;
            end else if (mneg_q) begin
              if (mul_m > rode_pkg::SMin) begin
                ovf_set = 1'b1;
                wr_val  = rode_pkg::SMin;
              end else begin
                wr_val = 64'd0 - mul_m;
              end
            end else if (mul_m[63]) begin
              ovf_set = 1'b1;
              wr_val  = rode_pkg::SMax;
            end else begin
              wr_val = mul_m;
            end
          end
        end
        rode_pkg::OP_SQRT: begin
          if (cnt_q == 7'd0 && opa_q[63]) begin
            neg_set = 1'b1;
          end else if (cnt_q == 7'd64) begin
            wr_en  = 1'b1;
            wr_val = root_d;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q     <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      yout_q  <= '0;
      stout_q <= rode_pkg::StatOk;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.load) begin
        xp_q  <= x_prev_i;
        xn_q  <= x_next_i;
        ovf_q <= 1'b0;
        neg_q <= 1'b0;
      end
      if (cmd_i.zero_y) begin
        y_q <= '0;
      end
      if (cmd_i.start) begin
        opa_q  <= src_a;
        opb_q  <= src_b;
        op_q   <= cmd_i.uop.op;
        dst_q  <= cmd_i.uop.dst;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (op_q == rode_pkg::OP_MUL) begin
          if (cnt_q == 7'd0) begin
            ma_q   <= opa_q[63] ? (64'd0 - opa_q) : opa_q;
            mb_q   <= opb_q[63] ? (64'd0 - opb_q) : opb_q;
            mneg_q <= opa_q[63] ^ opb_q[63];
            acc_q  <= '0;
          end else if (cnt_q != 7'd5) begin
            acc_q <= acc_q + pp_sh;
          end
        end else if (op_q == rode_pkg::OP_SQRT) begin
          if (cnt_q == 7'd0) begin
            acc_q  <= 128'(opa_q) << FRAC_BITS;
            rem_q  <= '0;
            root_q <= '0;
          end else begin
            acc_q  <= {acc_q[125:0], 2'b00};
            rem_q  <= rem_d;
            root_q <= root_d;
          end
        end
        if (wr_en || neg_set) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        if (ovf_set) begin
          ovf_q <= 1'b1;
        end
        if (neg_set) begin
          neg_q <= 1'b1;
          y_q   <= rode_pkg::SMax;
        end
      end
      if (wr_en) begin
        case (dst_q)
          rode_pkg::SRC_R0: r0_q <= wr_val;
          rode_pkg::SRC_R1: r1_q <= wr_val;
          rode_pkg::SRC_R2: r2_q <= wr_val;
          rode_pkg::SRC_R3: r3_q <= wr_val;
          rode_pkg::SRC_Y:  y_q  <= wr_val;
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        yout_q  <= y_q;
        stout_q <= neg_q ? rode_pkg::StatNeg : (ovf_q ? rode_pkg::StatOvf : rode_pkg::StatOk);
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.neg  = neg_q;
  assign y_value_o   = yout_q;
  assign status_o    = stout_q;

endmodule

// ===== src/riccati_ode_stepper_unit.sv =====
// Top level of the Riccati ODE stepper: configuration registers, sequencer and datapath.
//
// Advances u' = x^2 + u^2 by one step per beat, or clears u on restart (explicit Euler,
// closed-form implicit Euler or midpoint Runge-Kutta, chosen by the method register).
// Input channel: in_valid_i/in_ready_o with restart_i, x_prev_i, x_next_i.
// Output channel: out_valid_o/out_ready_i with y_value_o, status_o (one beat per input).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 method, 1 step size, 2 one over two h); write only while idle.
// Step time is set by the multiply step (four 32x32 partial products) and the
// one-bit-per-cycle square root; a restart beat skips the microcode, and a negative
// radicand ends the implicit step early.
// One beat is processed at a time; in_ready_o is high only between beats, and the
// next beat can be taken in the cycle after a result is loaded.
// A finished result sits in the output register; the next beat is taken while it
// waits, and that beat's result holds until the receiver takes the first.
// Reset clears y to zero, loads the register defaults and empties the output.
module riccati_ode_stepper_unit #(
  parameter int unsigned FRAC_BITS = rode_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rode_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rode_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  input  logic [63:0]                   x_prev_i,
  input  logic [63:0]                   x_next_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [63:0]                   y_value_o,
  output logic [1:0]                    status_o
);

  logic [1:0]                  method_q;
  logic [rode_pkg::StepW-1:0]  step_q;
  logic [rode_pkg::IhsW-1:0]   ihs_q;
  rode_pkg::cmd_t              cmd;
  rode_pkg::dp_stat_t          stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= rode_pkg::MethodRst;
      step_q   <= rode_pkg::StepRst;
      ihs_q    <= rode_pkg::IhsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rode_pkg::RegMethod: method_q <= cfg_data_i[1:0];
        rode_pkg::RegStep:   step_q   <= cfg_data_i[rode_pkg::StepW-1:0];
        rode_pkg::RegIhs:    ihs_q    <= cfg_data_i[rode_pkg::IhsW-1:0];
        default: ;
      endcase
    end
  end

  rode_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .method_i    (method_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  rode_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .step_i    (step_q),
    .ihs_i     (ihs_q),
    .x_prev_i  (x_prev_i),
    .x_next_i  (x_next_i),
    .y_value_o (y_value_o),
    .status_o  (status_o)
  );

endmodule

// ===== src/rode_checker.sv =====
// Port-level assertions for the Riccati ODE stepper, bound to the top level.
module rode_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] y_value_o,
  input logic [1:0]  status_o
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in progress");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_neg_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rode_pkg::StatNeg |-> y_value_o == rode_pkg::SMax)
    else $error("negative radicand without saturated result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(y_value_o) && $stable(status_o))
    else $error("output beat changed while stalled");

endmodule

bind riccati_ode_stepper_unit rode_checker u_rode_checker (.*);

// ===== tb/riccati_ode_stepper_checker.sv =====
// Checker for the Riccati ODE stepper: tracks config writes, predicts each step, compares results.
module riccati_ode_stepper_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rode_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rode_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          restart_i,
  input  logic [63:0]                   x_prev_i,
  input  logic [63:0]                   x_next_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [63:0]                   y_value_i,
  input  logic [1:0]                    status_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Fb = rode_pkg::FracBitsDef;

  typedef struct packed {
    logic [63:0] y;
    logic [1:0]  st;
  } step_result_t;

  step_result_t                 step_q[$];
  logic [1:0]                   meth;
  logic [rode_pkg::StepW-1:0]   h_raw;
  logic [rode_pkg::IhsW-1:0]    ihs_raw;
  logic signed [63:0]           y_state;

  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b, inout bit ovf);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      ovf = 1'b1;
      return s[64] ? rode_pkg::SMin : rode_pkg::SMax;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] ssub(logic [63:0] a, logic [63:0] b, inout bit ovf);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      ovf = 1'b1;
      return s[64] ? rode_pkg::SMin : rode_pkg::SMax;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b, inout bit ovf);
    logic        neg;
    logic [63:0] ma, mb, m;
    logic [127:0] p;
    neg = a[63] ^ b[63];
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    p = {64'd0, ma} * {64'd0, mb};
    p = p + (128'd1 << (Fb - 1));
    if ((p >> (64 + Fb)) != 0) begin
      ovf = 1'b1;
      return neg ? rode_pkg::SMin : rode_pkg::SMax;
    end
    m = 64'(p >> Fb);
    if (neg) begin
      if (m > rode_pkg::SMin) begin
        ovf = 1'b1;
        return rode_pkg::SMin;
      end
      return -m;
    end
    if (m[63]) begin
      ovf = 1'b1;
      return rode_pkg::SMax;
    end
    return m;
  endfunction

  function automatic logic [63:0] times4(logic [63:0] a, inout bit ovf);
    logic [63:0] t;
    t = sadd(a, a, ovf);
    return sadd(t, t, ovf);
  endfunction

  function automatic logic [63:0] slope_of(logic [63:0] x, logic [63:0] u, inout bit ovf);
    logic [63:0] xx, uu;
    xx = qmul(x, x, ovf);
    uu = qmul(u, u, ovf);
    return sadd(xx, uu, ovf);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0] res, cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= v) res = cand;
    end
    return res;
  endfunction

  function automatic step_result_t next_y(logic rst_y, logic [63:0] xp, logic [63:0] xn);
    step_result_t r;
    bit           ovf;
    logic [63:0]  h, c, one, t1, hx, t2, rad, s, d, k1, xm, ym, ny;
    ovf = 1'b0;
    r.st = rode_pkg::StatOk;
    h = {23'd0, h_raw};
    one = 64'd1 << Fb;
    if (rst_y) begin
      r.y = '0;
      return r;
    end
    if (meth == rode_pkg::MethImplicit) begin
      t1 = times4(qmul(h, y_state, ovf), ovf);
      hx = qmul(h, xn, ovf);
      t2 = times4(qmul(hx, hx, ovf), ovf);
      rad = ssub(ssub(one, t1, ovf), t2, ovf);
      if (rad[63]) begin
        ny = rode_pkg::SMax;
        r.st = rode_pkg::StatNeg;
      end else begin
        s = floor_sqrt({64'd0, rad} << Fb);
        d = ssub(one, s, ovf);
        ny = qmul(d, {1'b0, ihs_raw}, ovf);
      end
    end else if (meth == rode_pkg::MethMidpoint) begin
      c = h >> 1;
      k1 = slope_of(xp, y_state, ovf);
      xm = sadd(xp, c, ovf);
      ym = sadd(y_state, qmul(c, k1, ovf), ovf);
      ny = sadd(y_state, qmul(h, slope_of(xm, ym, ovf), ovf), ovf);
    end else begin
      ny = sadd(y_state, qmul(h, slope_of(xp, y_state, ovf), ovf), ovf);
    end
    if (r.st == rode_pkg::StatOk && ovf) r.st = rode_pkg::StatOvf;
    r.y = ny;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fail_count_o++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t want;
    if (!rst_ni) begin
      meth <= rode_pkg::MethodRst;
      h_raw <= rode_pkg::StepRst;
      ihs_raw <= rode_pkg::IhsRst;
      y_state <= '0;
      step_q.delete();
      fail_count_o = 0;
      checked_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rode_pkg::RegMethod: meth <= cfg_data_i[1:0];
          rode_pkg::RegStep:   h_raw <= cfg_data_i[rode_pkg::StepW-1:0];
          rode_pkg::RegIhs:    ihs_raw <= cfg_data_i[rode_pkg::IhsW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        want = next_y(restart_i, x_prev_i, x_next_i);
        y_state <= want.y;
        step_q.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        checked_o <= checked_o + 1;
        if (step_q.size() == 0) begin
          report_mismatch("unexpected beat y_value", y_value_i, '0);
        end else begin
          want = step_q.pop_front();
          if (y_value_i !== want.y) report_mismatch("y_value", y_value_i, want.y);
          if (status_i !== want.st) report_mismatch("status", status_i, want.st);
        end
      end
      pending_o <= $unsigned(step_q.size());
    end
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top: drives steps and config for the Riccati ODE stepper and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemsPerSeg = 90;
  localparam longint unsigned CycleLimit = 3_000_000;
  localparam int unsigned Dw = rode_pkg::CfgDataW;
  localparam logic [1:0] MethUnused = 2'd3;
  localparam logic [rode_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [rode_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [rode_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          restart = 1'b0;
  logic [63:0]                   x_prev = '0;
  logic [63:0]                   x_next = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [63:0]                   y_value;
  logic [1:0]                    status;
  int unsigned                   fail_count, pending, checked;
  int unsigned                   tx_idle_pct = 25, rx_idle_pct = 88, sent = 0;
  longint unsigned               cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  riccati_ode_stepper_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .restart_i(restart), .x_prev_i(x_prev), .x_next_i(x_next),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .y_value_o(y_value), .status_o(status)
  );

  riccati_ode_stepper_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .restart_i(restart), .x_prev_i(x_prev), .x_next_i(x_next),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .y_value_i(y_value), .status_i(status),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [rode_pkg::CfgIdxW-1:0] idx,
                           logic [rode_pkg::CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic send_step(logic rs, logic [63:0] xp, logic [63:0] xn);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    restart <= rs;
    x_prev <= xp;
    x_next <= xn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [63:0] rand_x();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $signed(r) >>> 22;
      5, 6:          return $signed(r) >>> 12;
      7, 8:          return r;
      default: begin
        case ($urandom_range(3))
          0: return rode_pkg::SMax;
          1: return rode_pkg::SMin;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [62:0] ihs_for(logic [40:0] h);
    logic [127:0] q;
    q = (128'd1 << 79) / h;
    if (q > 128'h7FFF_FFFF_FFFF_FFFF) return 63'h7FFF_FFFF_FFFF_FFFF;
    if (q < 128'd549755813888) return 63'd549755813888;
    return q[62:0];
  endfunction

  initial begin
    logic [40:0] h;
    logic [62:0] ihs;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults (explicit), then implicit, midpoint, unused method code
    send_step(1'b1, rode_pkg::SMax, rode_pkg::SMin);
    send_step(1'b0, '0, '0);
    send_step(1'b0, rode_pkg::SMax, '0);
    send_step(1'b0, rode_pkg::SMin, '0);
    send_step(1'b0, '1, '0);
    send_step(1'b0, 64'd1 << 40, '0);
    drain();
    write_reg(rode_pkg::RegMethod, Dw'(rode_pkg::MethImplicit));
    send_step(1'b1, '0, '0);
    send_step(1'b0, '0, '0);
    send_step(1'b0, '0, 64'h0000_0200_0000_0000);
    send_step(1'b0, '0, rode_pkg::SMax);
    send_step(1'b0, '0, rode_pkg::SMin);
    send_step(1'b1, '0, '0);
    drain();
    write_reg(rode_pkg::RegStep, Dw'(41'd1 << 40));
    write_reg(rode_pkg::RegIhs, Dw'(63'd549755813888));
    send_step(1'b0, '0, 64'hFFFF_FF80_0000_0000);
    send_step(1'b1, '0, '0);
    drain();
    write_reg(rode_pkg::RegMethod, Dw'(rode_pkg::MethMidpoint));
    send_step(1'b0, 64'h0000_0100_0000_0000, '0);
    send_step(1'b0, rode_pkg::SMax, '1);
    send_step(1'b1, '0, '0);
    drain();
    write_reg(rode_pkg::RegMethod, Dw'(MethUnused));
    write_reg(rode_pkg::RegStep, Dw'(41'd1));
    write_reg(rode_pkg::RegIhs, Dw'(63'h7FFF_FFFF_FFFF_FFFF));
    write_reg(RegUnused, '1);
    send_step(1'b0, rode_pkg::SMin, '0);
    send_step(1'b0, 64'h0000_0080_0000_0000, '0);
    send_step(1'b1, '1, '1);

    for (int seg = 0; seg < 9; seg++) begin
      drain();
      case (seg / 3)
        0: begin tx_idle_pct = 25; rx_idle_pct = 88; end
        1: begin tx_idle_pct = 88; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case ($urandom_range(3))
        0: h = 41'd1;
        1: h = 41'd1 << 40;
        2: h = rode_pkg::StepRst;
        default: h = 41'($urandom_range(1 << 30, 1)) << $urandom_range(10);
      endcase
      ihs = ($urandom_range(3) == 0) ? 63'({$urandom, $urandom}) : ihs_for(h);
      if (ihs < 63'd549755813888) ihs = 63'd549755813888;
      write_reg(rode_pkg::RegMethod, Dw'(seg % 4));
      write_reg(rode_pkg::RegStep, Dw'(h));
      write_reg(rode_pkg::RegIhs, Dw'(ihs));
      send_step(1'b1, '0, '0);
      for (int i = 0; i < ItemsPerSeg; i++)
        send_step($urandom_range(9) == 0, rand_x(), rand_x());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d steps over all methods and step sizes, %0d results checked",
             sent, checked);
    $display("three handshake idling mixes, config extremes, restarts and saturation");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
